// File: rtl/mss_pkg.sv
package mss_pkg;

  // Fixed field widths
  localparam int VALUE_W = 32;
  localparam int SWAP_W  = 6;

  // Largest swap count the result field can carry
  localparam logic [SWAP_W-1:0] COUNT_MAX = 6'd63;

  // Commands from the sequencer to the sorting chain
  typedef struct packed {
    logic insert;
    logic drain;
    logic clear;
  } mss_chain_ctl_t;

  // Commands from the sequencer to the cycle walker
  typedef struct packed {
    logic start;
    logic wr_en;
  } mss_walk_ctl_t;

endpackage

// File: rtl/mss_cell.sv
module mss_cell #(
  parameter int IDX_W = 6
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mss_pkg::mss_chain_ctl_t              ctl,
  input  logic signed [mss_pkg::VALUE_W-1:0]   new_value,
  input  logic        [IDX_W-1:0]              new_src,
  input  logic                                 prev_take,
  input  logic signed [mss_pkg::VALUE_W-1:0]   prev_value,
  input  logic        [IDX_W-1:0]              prev_src,
  input  logic                                 prev_valid,
  input  logic signed [mss_pkg::VALUE_W-1:0]   next_value,
  input  logic        [IDX_W-1:0]              next_src,
  input  logic                                 next_valid,
  output logic signed [mss_pkg::VALUE_W-1:0]   value,
  output logic        [IDX_W-1:0]              src,
  output logic                                 valid,
  output logic                                 take
);
  import mss_pkg::*;

  logic gt;

  // Strictly greater keeps equal values in arrival order
  assign gt   = valid && (value > new_value);
  assign take = !valid || gt;

  // Clear empties the row; insert shifts the tail right; drain shifts everything toward the head
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.drain) begin
      value <= next_value;
      src   <= next_src;
      valid <= next_valid;
    end else if (ctl.insert && take) begin
      if (prev_take) begin
        value <= prev_value;
        src   <= prev_src;
        valid <= prev_valid;
      end else begin
        value <= new_value;
        src   <= new_src;
        valid <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/mss_chain.sv
module mss_chain #(
  parameter int N     = 64,
  parameter int IDX_W = 6
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mss_pkg::mss_chain_ctl_t              ctl,
  input  logic signed [mss_pkg::VALUE_W-1:0]   new_value,
  input  logic        [IDX_W-1:0]              new_src,
  output logic        [IDX_W-1:0]              head_src,
  output logic                                 head_valid
);
  import mss_pkg::*;

  logic signed [VALUE_W-1:0] c_value [N];
  logic        [IDX_W-1:0]   c_src   [N];
  logic                      c_valid [N];
  logic                      c_take  [N];

  // Row of cells, each wired to its left and right neighbor
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [VALUE_W-1:0] p_value;
    logic        [IDX_W-1:0]   p_src;
    logic                      p_valid;
    logic                      p_take;
    logic signed [VALUE_W-1:0] n_value;
    logic        [IDX_W-1:0]   n_src;
    logic                      n_valid;

    if (i == 0) begin : g_head
      assign p_value = '0;
      assign p_src   = '0;
      assign p_valid = 1'b0;
      assign p_take  = 1'b0;
    end else begin : g_body
      assign p_value = c_value[i-1];
      assign p_src   = c_src[i-1];
      assign p_valid = c_valid[i-1];
      assign p_take  = c_take[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign n_value = '0;
      assign n_src   = '0;
      assign n_valid = 1'b0;
    end else begin : g_mid
      assign n_value = c_value[i+1];
      assign n_src   = c_src[i+1];
      assign n_valid = c_valid[i+1];
    end

    mss_cell #(.IDX_W(IDX_W)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_value  (new_value),
      .new_src    (new_src),
      .prev_take  (p_take),
      .prev_value (p_value),
      .prev_src   (p_src),
      .prev_valid (p_valid),
      .next_value (n_value),
      .next_src   (n_src),
      .next_valid (n_valid),
      .value      (c_value[i]),
      .src        (c_src[i]),
      .valid      (c_valid[i]),
      .take       (c_take[i])
    );
  end

  assign head_src   = c_src[0];
  assign head_valid = c_valid[0];

endmodule

// File: rtl/mss_walk.sv
module mss_walk #(
  parameter int N     = 64,
  parameter int IDX_W = 6,
  parameter int CNT_W = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mss_pkg::mss_walk_ctl_t  ctl,
  input  logic [CNT_W-1:0]        count,
  input  logic [IDX_W-1:0]        wr_addr,
  input  logic [IDX_W-1:0]        wr_data,
  output logic                    done,
  output logic [CNT_W-1:0]        cycle_count
);
  import mss_pkg::*;

  typedef enum logic [1:0] {
    W_IDLE,
    W_SCAN,
    W_FOLLOW
  } walk_state_t;

  walk_state_t           state;
  logic [IDX_W-1:0]      idx;
  logic [N-1:0]          visited;
  logic [IDX_W-1:0]      mem [N];
  logic [IDX_W-1:0]      mem_q;
  logic [IDX_W-1:0]      rd_addr;
  logic                  last_idx;

  assign last_idx = (CNT_W'(idx) == count - CNT_W'(1));
  assign rd_addr  = (state == W_SCAN) ? idx : mem_q;

  // Permutation store: sorted position -> arrival index
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  // Scan for unvisited starts, then follow each cycle one link a step
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= W_IDLE;
      idx         <= '0;
      visited     <= '0;
      cycle_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        state       <= W_SCAN;
        idx         <= '0;
        visited     <= '0;
        cycle_count <= '0;
      end else begin
        unique case (state)
          W_IDLE: begin
            state <= W_IDLE;
          end
          W_SCAN: begin
            if (visited[idx]) begin
              if (last_idx) begin
                done  <= 1'b1;
                state <= W_IDLE;
              end else begin
                idx <= idx + IDX_W'(1);
              end
            end else begin
              visited[idx] <= 1'b1;
              cycle_count  <= cycle_count + CNT_W'(1);
              state        <= W_FOLLOW;
            end
          end
          W_FOLLOW: begin
            if (visited[mem_q]) begin
              if (last_idx) begin
                done  <= 1'b1;
                state <= W_IDLE;
              end else begin
                idx   <= idx + IDX_W'(1);
                state <= W_SCAN;
              end
            end else begin
              visited[mem_q] <= 1'b1;
            end
          end
          default: begin
            state <= W_IDLE;
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/min_swaps_to_sort.sv
// Minimum swap count to sort a list of signed 32-bit values.
//
// Input channel (element_value, last_element, in_valid/in_ready): one value
// per transaction, last_element marks the end of a list. Output channel
// (swap_count, overflow, out_valid/out_ready): one transaction per list.
//
// Values are inserted into a row of compare/shift cells, one value per
// cycle while in_ready is high. After the last value the row is drained
// into the permutation store and the cycle walker counts the permutation
// cycles with one scan step and one follow step per entry. The input
// stays closed after the last value until the result has taken the output
// register. Values beyond MAX_ITEMS are dropped and flag overflow.
//
// The result sits in an output register; the next list is loaded while it
// waits. A stalled receiver only holds the block once a second result is
// ready. Reset empties the row, drops any partial list and clears out_valid.
module min_swaps_to_sort #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [mss_pkg::VALUE_W-1:0]  element_value,
  input  logic                                last_element,
  input  logic                                in_valid,
  output logic                                in_ready,
  output logic        [mss_pkg::SWAP_W-1:0]   swap_count,
  output logic                                overflow,
  output logic                                out_valid,
  input  logic                                out_ready
);
  import mss_pkg::*;

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int SAT_W = (CNT_W > SWAP_W) ? CNT_W : SWAP_W;

  typedef enum logic [1:0] {
    S_LOAD,
    S_DRAIN,
    S_WALK,
    S_DONE
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      drain_k;
  logic                  ovf;

  mss_chain_ctl_t        chain_ctl;
  mss_walk_ctl_t         walk_ctl;
  logic [IDX_W-1:0]      head_src;
  logic                  head_valid;
  logic                  walk_done;
  logic [CNT_W-1:0]      cycle_count;

  logic                  in_fire;
  logic                  room;
  logic                  drain_last;
  logic                  out_free;
  logic [SAT_W-1:0]      diff;
  logic [SWAP_W-1:0]     swaps;

  assign in_ready   = (state == S_LOAD);
  assign in_fire    = in_valid && in_ready;
  assign room       = (count < CNT_W'(MAX_ITEMS));
  assign drain_last = (drain_k == count - CNT_W'(1));
  assign out_free   = !out_valid || out_ready;

  // Swaps = entries minus permutation cycles, saturated to the field
  assign diff  = SAT_W'(count - cycle_count);
  assign swaps = (diff > SAT_W'(COUNT_MAX)) ? COUNT_MAX : diff[SWAP_W-1:0];

  // Chain and walker commands
  always_comb begin
    chain_ctl.insert = in_fire && room;
    chain_ctl.drain  = (state == S_DRAIN);
    chain_ctl.clear  = (state == S_DONE) && out_free;
    walk_ctl.wr_en   = (state == S_DRAIN);
    walk_ctl.start   = (state == S_DRAIN) && drain_last;
  end

  mss_chain #(.N(MAX_ITEMS), .IDX_W(IDX_W)) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctl        (chain_ctl),
    .new_value  (element_value),
    .new_src    (count[IDX_W-1:0]),
    .head_src   (head_src),
    .head_valid (head_valid)
  );

  mss_walk #(.N(MAX_ITEMS), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_walk (
    .clk         (clk),
    .rst         (rst),
    .ctl         (walk_ctl),
    .count       (count),
    .wr_addr     (drain_k[IDX_W-1:0]),
    .wr_data     (head_src),
    .done        (walk_done),
    .cycle_count (cycle_count)
  );

  // Sequencer with the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      drain_k   <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // new result takes the register, otherwise an accepted one leaves it
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (room) begin
              count <= count + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (last_element) begin
              drain_k <= '0;
              state   <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          drain_k <= drain_k + CNT_W'(1);
          if (drain_last) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            swap_count <= swaps;
            overflow   <= ovf;
            count      <= '0;
            ovf        <= 1'b0;
            state      <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Stored count never exceeds the row length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("stored count above MAX_ITEMS");

  // The end of a list closes the input once it is accepted
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_element |=> !in_ready)
    else $error("input still open after last element");

  // While loading, a nonzero count means the head cell holds data
  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) && (count != '0) |-> head_valid)
    else $error("head cell empty with values stored");

  // Cycle count never exceeds the number of stored values at the result
  a_cycles_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (cycle_count <= count))
    else $error("more permutation cycles than entries");

endmodule
